>>> hw/rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// types and constants shared by the shape pair contact test
// ----------------------------------------------------------------------------
package scp_pkg;

   localparam logic [1:0] OP_BOX_BOX    = 2'd0;
   localparam logic [1:0] OP_CIRC_CIRC  = 2'd1;
   localparam logic [1:0] OP_BOX_CIRC   = 2'd2;
   localparam logic [1:0] OP_NONE       = 2'd3;

   localparam int unsigned CSR_ADDR_W   = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOX_TOL = 3'd0;
   localparam logic [7:0] BOX_TOL_RESET = 8'd1;

   localparam logic signed [15:0] NORM_ONE  = 16'sd16384;
   localparam logic signed [23:0] PEN_MAX   = 24'sh7fffff;
   localparam logic signed [23:0] PEN_MIN   = -24'sh800000;

   localparam int unsigned SQ_STEPS = 24;
   localparam int unsigned DV_STEPS = 15;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [23:0] a_center_x;
      logic signed [23:0] a_center_y;
      logic [22:0]        a_width;
      logic [22:0]        a_height;
      logic [22:0]        a_radius;
      logic signed [23:0] b_center_x;
      logic signed [23:0] b_center_y;
      logic [22:0]        b_width;
      logic [22:0]        b_height;
      logic [22:0]        b_radius;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [23:0] penetration;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         op;
      logic               box_hit;
      logic signed [15:0] box_nx;
      logic signed [15:0] box_ny;
      logic signed [23:0] box_pen;
      logic               chit;
      logic [23:0]        rad;
      logic               neg_x;
      logic               neg_y;
      logic [23:0]        mag_x;
      logic [23:0]        mag_y;
   } meta_type;

endpackage

>>> hw/rtl/shape_pair_contact_test.sv
// ----------------------------------------------------------------------------
// shape_pair_contact_test
// narrow phase contact test for one pair of 2d shapes per transaction
// ----------------------------------------------------------------------------
// A pair enters on the req channel (req_valid, req_stall, req_payload) and
// its result leaves on the rsp channel (rsp_valid, rsp_stall, rsp_payload)
// in order, one result per pair. The user must write the box_tolerance
// register over the apb port only while the block is idle; it is unchecked.
// The path from the accepting edge to rsp_valid runs through 44
// register stages: three setup stages, one compare stage, a 24 stage square
// root and a 15 stage divider for the normal, then the output register.
// Throughput is one pair per cycle while the receiver does not stall.
// Reset clears all valid bits and sets box_tolerance to 1.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall rises; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module shape_pair_contact_test (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  scp_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output scp_pkg::rsp_type              rsp_payload,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [scp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import scp_pkg::*;

   localparam int unsigned CHAIN = SQ_STEPS + DV_STEPS;

   logic adv;
   logic [7:0] tol_ff;

   // configuration
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_BOX_TOL) ? {24'd0, tol_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= BOX_TOL_RESET;
      end else if (psel && penable && pwrite && paddr == CSR_BOX_TOL) begin
         tol_ff <= pwdata[7:0];
      end
   end

   logic rsp_valid_ff;
   rsp_type rsp_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // stage 1
   logic s1_v_ff;
   logic [1:0] s1_op_ff;
   logic signed [24:0] s1_dx_ff, s1_dy_ff, s1_cx_ff, s1_cy_ff;
   logic signed [25:0] s1_lox_ff, s1_hix_ff, s1_loy_ff, s1_hiy_ff;
   logic [23:0] s1_sumw_ff, s1_sumh_ff, s1_rs_ff, s1_r2_ff;

   logic signed [25:0] ax2, ay2;
   assign ax2 = $signed({req_payload.a_center_x[23], req_payload.a_center_x, 1'b0});
   assign ay2 = $signed({req_payload.a_center_y[23], req_payload.a_center_y, 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff   <= req_payload.operation;
         s1_dx_ff   <= $signed({req_payload.b_center_x[23], req_payload.b_center_x})
                     - $signed({req_payload.a_center_x[23], req_payload.a_center_x});
         s1_dy_ff   <= $signed({req_payload.b_center_y[23], req_payload.b_center_y})
                     - $signed({req_payload.a_center_y[23], req_payload.a_center_y});
         s1_cx_ff   <= $signed({req_payload.b_center_x, 1'b0});
         s1_cy_ff   <= $signed({req_payload.b_center_y, 1'b0});
         s1_lox_ff  <= ax2 - $signed({3'b000, req_payload.a_width});
         s1_hix_ff  <= ax2 + $signed({3'b000, req_payload.a_width});
         s1_loy_ff  <= ay2 - $signed({3'b000, req_payload.a_height});
         s1_hiy_ff  <= ay2 + $signed({3'b000, req_payload.a_height});
         s1_sumw_ff <= {1'b0, req_payload.a_width} + {1'b0, req_payload.b_width};
         s1_sumh_ff <= {1'b0, req_payload.a_height} + {1'b0, req_payload.b_height};
         s1_rs_ff   <= {1'b0, req_payload.a_radius} + {1'b0, req_payload.b_radius};
         s1_r2_ff   <= {req_payload.b_radius, 1'b0};
      end
   end

   // stage 2
   logic s2_v_ff;
   logic [1:0] s2_op_ff;
   logic signed [26:0] s2_ox_ff, s2_oy_ff, s2_dvx_ff, s2_dvy_ff;
   logic s2_dxpos_ff, s2_dypos_ff;
   logic [23:0] s2_rad_ff;

   logic [24:0] absx, absy;
   logic signed [25:0] px, py, cxe, cye;
   logic signed [26:0] ddx_in, ddy_in;

   assign absx = s1_dx_ff[24] ? 25'(-s1_dx_ff) : 25'(s1_dx_ff);
   assign absy = s1_dy_ff[24] ? 25'(-s1_dy_ff) : 25'(s1_dy_ff);
   assign cxe  = $signed({s1_cx_ff[24], s1_cx_ff});
   assign cye  = $signed({s1_cy_ff[24], s1_cy_ff});

   always_comb begin
      if (cxe < s1_lox_ff) px = s1_lox_ff;
      else if (cxe > s1_hix_ff) px = s1_hix_ff;
      else px = cxe;
      if (cye < s1_loy_ff) py = s1_loy_ff;
      else if (cye > s1_hiy_ff) py = s1_hiy_ff;
      else py = cye;
      ddx_in = $signed({cxe[25], cxe}) - $signed({px[25], px});
      ddy_in = $signed({cye[25], cye}) - $signed({py[25], py});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_op_ff    <= s1_op_ff;
         s2_ox_ff    <= $signed({3'b000, s1_sumw_ff}) - $signed({1'b0, absx, 1'b0});
         s2_oy_ff    <= $signed({3'b000, s1_sumh_ff}) - $signed({1'b0, absy, 1'b0});
         s2_dxpos_ff <= !s1_dx_ff[24] && (s1_dx_ff != '0);
         s2_dypos_ff <= !s1_dy_ff[24] && (s1_dy_ff != '0);
         s2_dvx_ff   <= (s1_op_ff == OP_CIRC_CIRC) ?
                        $signed({{2{s1_dx_ff[24]}}, s1_dx_ff}) : ddx_in;
         s2_dvy_ff   <= (s1_op_ff == OP_CIRC_CIRC) ?
                        $signed({{2{s1_dy_ff[24]}}, s1_dy_ff}) : ddy_in;
         s2_rad_ff   <= (s1_op_ff == OP_CIRC_CIRC) ? s1_rs_ff : s1_r2_ff;
      end
   end

   // stage 3
   logic s3_v_ff;
   meta_type s3_meta_ff;
   logic [51:0] s3_sqx_ff, s3_sqy_ff;
   logic [47:0] s3_rr_ff;

   meta_type s3_meta_in;
   logic signed [26:0] mn, mn_half;
   logic signed [53:0] sqx_full, sqy_full;
   logic [26:0] magx, magy;

   assign sqx_full = s2_dvx_ff * s2_dvx_ff;
   assign sqy_full = s2_dvy_ff * s2_dvy_ff;
   assign magx = s2_dvx_ff[26] ? 27'(-s2_dvx_ff) : 27'(s2_dvx_ff);
   assign magy = s2_dvy_ff[26] ? 27'(-s2_dvy_ff) : 27'(s2_dvy_ff);

   always_comb begin
      s3_meta_in = '0;
      s3_meta_in.op = s2_op_ff;
      if (s2_ox_ff <= s2_oy_ff) begin
         s3_meta_in.box_nx = s2_dxpos_ff ? NORM_ONE : -NORM_ONE;
         s3_meta_in.box_ny = '0;
         mn = s2_ox_ff;
      end else begin
         s3_meta_in.box_nx = '0;
         s3_meta_in.box_ny = s2_dypos_ff ? NORM_ONE : -NORM_ONE;
         mn = s2_oy_ff;
      end
      mn_half = mn >>> 1;
      if (mn_half > $signed({{3{PEN_MAX[23]}}, PEN_MAX})) s3_meta_in.box_pen = PEN_MAX;
      else if (mn_half < $signed({{3{PEN_MIN[23]}}, PEN_MIN})) s3_meta_in.box_pen = PEN_MIN;
      else s3_meta_in.box_pen = mn_half[23:0];
      s3_meta_in.box_hit = mn > -$signed({18'd0, tol_ff, 1'b0});
      s3_meta_in.rad   = s2_rad_ff;
      s3_meta_in.neg_x = s2_dvx_ff[26];
      s3_meta_in.neg_y = s2_dvy_ff[26];
      s3_meta_in.mag_x = magx[23:0];
      s3_meta_in.mag_y = magy[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_meta_ff <= s3_meta_in;
         s3_sqx_ff  <= sqx_full[51:0];
         s3_sqy_ff  <= sqy_full[51:0];
         s3_rr_ff   <= s2_rad_ff * s2_rad_ff;
      end
   end

   // stage 4 and the long chain
   logic     vld_ff  [0:CHAIN];
   meta_type meta_ff [0:CHAIN];
   logic [47:0] sq_n_ff    [0:SQ_STEPS];
   logic [47:0] sq_root_ff [0:SQ_STEPS];

   logic [52:0] d2;
   logic chit_in;
   meta_type s4_meta_in;
   assign d2 = {1'b0, s3_sqx_ff} + {1'b0, s3_sqy_ff};
   assign chit_in = d2 < {5'd0, s3_rr_ff};

   always_comb begin
      s4_meta_in = s3_meta_ff;
      s4_meta_in.chit = chit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0]    <= s4_meta_in;
         sq_n_ff[0]    <= chit_in ? d2[47:0] : 48'd0;
         sq_root_ff[0] <= '0;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < CHAIN; gi++) begin : g_chain
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[gi+1] <= 1'b0;
            end else if (adv) begin
               vld_ff[gi+1] <= vld_ff[gi];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               meta_ff[gi+1] <= meta_ff[gi];
            end
         end
      end

      for (gi = 0; gi < SQ_STEPS; gi++) begin : g_sqrt
         localparam int unsigned SH = 2 * (SQ_STEPS - 1 - gi);
         logic [47:0] bit_c, trial, n_in, root_in;
         logic ge;
         assign bit_c = 48'd1 << SH;
         assign trial = sq_root_ff[gi] + bit_c;
         assign ge    = sq_n_ff[gi] >= trial;
         assign n_in    = ge ? sq_n_ff[gi] - trial : sq_n_ff[gi];
         assign root_in = ge ? (sq_root_ff[gi] >> 1) + bit_c : sq_root_ff[gi] >> 1;
         always_ff @(posedge clock) begin
            if (adv) begin
               sq_n_ff[gi+1]    <= n_in;
               sq_root_ff[gi+1] <= root_in;
            end
         end
      end
   endgenerate

   // normal divider: magnitude * 16384 / distance, one quotient bit per stage
   logic [24:0] dv_rx_ff   [0:DV_STEPS-1];
   logic [24:0] dv_ry_ff   [0:DV_STEPS-1];
   logic [14:0] dv_qx_ff   [0:DV_STEPS-1];
   logic [14:0] dv_qy_ff   [0:DV_STEPS-1];
   logic [23:0] dv_dist_ff [0:DV_STEPS-1];

   generate
      for (gi = 0; gi < DV_STEPS; gi++) begin : g_div
         logic [24:0] rx, ry, rx1, ry1;
         logic [14:0] qx, qy;
         logic [23:0] dvsr;
         logic gex, gey;
         if (gi == 0) begin : g_first
            assign rx   = {1'b0, meta_ff[SQ_STEPS].mag_x};
            assign ry   = {1'b0, meta_ff[SQ_STEPS].mag_y};
            assign qx   = '0;
            assign qy   = '0;
            assign dvsr = sq_root_ff[SQ_STEPS][23:0];
         end else begin : g_next
            assign rx   = dv_rx_ff[gi-1];
            assign ry   = dv_ry_ff[gi-1];
            assign qx   = dv_qx_ff[gi-1];
            assign qy   = dv_qy_ff[gi-1];
            assign dvsr = dv_dist_ff[gi-1];
         end
         assign gex = rx >= {1'b0, dvsr};
         assign gey = ry >= {1'b0, dvsr};
         assign rx1 = gex ? rx - {1'b0, dvsr} : rx;
         assign ry1 = gey ? ry - {1'b0, dvsr} : ry;
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rx_ff[gi]   <= {rx1[23:0], 1'b0};
               dv_ry_ff[gi]   <= {ry1[23:0], 1'b0};
               dv_qx_ff[gi]   <= {qx[13:0], gex};
               dv_qy_ff[gi]   <= {qy[13:0], gey};
               dv_dist_ff[gi] <= dvsr;
            end
         end
      end
   endgenerate

   // final assembly
   meta_type fm;
   logic [23:0] fdist;
   logic [24:0] pdiff;
   logic signed [15:0] nxv, nyv;
   rsp_type rsp_in;

   assign fm    = meta_ff[CHAIN];
   assign fdist = dv_dist_ff[DV_STEPS-1];
   assign pdiff = {1'b0, fm.rad} - {1'b0, fdist};
   assign nxv = fm.neg_x ? -$signed({1'b0, dv_qx_ff[DV_STEPS-1]})
                         :  $signed({1'b0, dv_qx_ff[DV_STEPS-1]});
   assign nyv = fm.neg_y ? -$signed({1'b0, dv_qy_ff[DV_STEPS-1]})
                         :  $signed({1'b0, dv_qy_ff[DV_STEPS-1]});

   always_comb begin
      rsp_in = '0;
      unique case (fm.op)
         OP_BOX_BOX: begin
            rsp_in.hit         = fm.box_hit;
            rsp_in.normal_x    = fm.box_nx;
            rsp_in.normal_y    = fm.box_ny;
            rsp_in.penetration = fm.box_pen;
         end
         OP_CIRC_CIRC, OP_BOX_CIRC: begin
            if (fm.chit) begin
               rsp_in.hit = 1'b1;
               if (fdist == '0) begin
                  rsp_in.normal_x = '0;
                  rsp_in.normal_y = NORM_ONE;
               end else begin
                  rsp_in.normal_x = nxv;
                  rsp_in.normal_y = nyv;
               end
               if (fm.op == OP_BOX_CIRC) begin
                  rsp_in.penetration = {1'b0, pdiff[23:1]};
               end else if (pdiff[24:23] != 2'b00) begin
                  rsp_in.penetration = PEN_MAX;
               end else begin
                  rsp_in.penetration = pdiff[23:0];
               end
            end
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[CHAIN];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
